>>> rtl/awc_pkg.sv
// Shared types, constants and the arctangent table of the Ackermann wheel command unit.
package awc_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 12;
	localparam int CORDIC_STEPS_DEF    = 16;

	localparam int SPEED_W     = 16;
	localparam int STEER_W     = 14;
	localparam int RATE_W      = 24;
	localparam int ANG_W       = 14;
	localparam int CFG_W       = 16;
	localparam int LIM_W       = 13;
	localparam int CFG_IDX_W   = 3;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 56;

	localparam int ROT_W  = 34;   // sin/cos datapath, Q30 plus growth
	localparam int PROD_W = 52;   // 2*L*sin, 2*L*cos +- W*sin and vectoring datapath
	localparam int Z_W    = 33;   // angle accumulator, Q30
	localparam int REM_W  = 17;   // divider remainder, holds 2*radius

	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WHEELBASE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT        = 3'd4;

	localparam logic signed [Z_W-1:0]   Q30_HALF_PI = 33'sd1686629713;
	localparam logic signed [ROT_W-1:0] GAIN_INV    = 34'sd652032874;

	localparam logic [RATE_W:0]          RATE_Q_MAX   = 25'd8388608;
	localparam logic signed [RATE_W-1:0] RATE_POS_MAX = 24'sh7FFFFF;
	localparam logic signed [RATE_W-1:0] RATE_NEG_MIN = 24'sh800000;

	typedef struct packed {
		logic neg;
		logic rz;   // wheel radius is zero
		logic sz;   // speed is zero
	} div_flags_t;

	typedef struct packed {
		logic neg;  // n/d is negative
		logic dz;   // divisor is zero
	} vec_flags_t;

	typedef struct packed {
		logic sneg; // steer to the right
		logic nz;   // steer survives deadband and limit
	} ang_side_t;

	typedef struct packed {
		logic [RATE_W:0] q;
		div_flags_t      fl;
	} div_res_t;

	typedef struct packed {
		logic signed [Z_W-1:0] zi;
		logic signed [Z_W-1:0] zo;
		vec_flags_t            ifl;
		vec_flags_t            ofl;
		ang_side_t             side;
	} ang_res_t;

	// atan(2^-i) in Q30
	function automatic logic signed [Z_W-1:0] atan_entry(input int i);
		case (i)
			0: return 33'sd843314857;
			1: return 33'sd497837829;
			2: return 33'sd263043836;
			3: return 33'sd133525158;
			4: return 33'sd67021686;
			5: return 33'sd33543515;
			6: return 33'sd16775850;
			7: return 33'sd8388437;
			8: return 33'sd4194282;
			9: return 33'sd2097149;
			10: return 33'sd1048575;
			11: return 33'sd524287;
			12: return 33'sd262143;
			13: return 33'sd131071;
			14: return 33'sd65535;
			15: return 33'sd32767;
			16: return 33'sd16383;
			17: return 33'sd8191;
			18: return 33'sd4095;
			19: return 33'sd2047;
			20: return 33'sd1023;
			21: return 33'sd511;
			22: return 33'sd255;
			23: return 33'sd127;
			default: return '0;
		endcase
	endfunction

endpackage

>>> rtl/awc_div_cell.sv
// One restoring division step: brings in one dividend bit, makes one quotient bit.
module awc_div_cell #(
	parameter int DW = 29
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [awc_pkg::REM_W-1:0]    rem_in,
	input  logic [DW-1:0]                dvd_in,
	input  logic [DW-1:0]                quo_in,
	input  logic [awc_pkg::REM_W-1:0]    dvs_in,
	input  awc_pkg::div_flags_t          fl_in,
	output logic [awc_pkg::REM_W-1:0]    rem_s1,
	output logic [DW-1:0]                dvd_s1,
	output logic [DW-1:0]                quo_s1,
	output logic [awc_pkg::REM_W-1:0]    dvs_s1,
	output awc_pkg::div_flags_t          fl_s1
);
	import awc_pkg::*;

	logic [REM_W:0] trial;
	logic           fits;

	assign trial = {rem_in, dvd_in[DW-1]};
	assign fits  = trial >= {1'b0, dvs_in};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= fits ? REM_W'(trial - {1'b0, dvs_in}) : REM_W'(trial);
			dvd_s1 <= {dvd_in[DW-2:0], 1'b0};
			quo_s1 <= {quo_in[DW-2:0], fits};
			dvs_s1 <= dvs_in;
			fl_s1  <= fl_in;
		end
	end

endmodule

>>> rtl/awc_rot_cell.sv
// One rotation CORDIC step of the sin/cos chain.
module awc_rot_cell #(
	parameter int STEP = 0
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [awc_pkg::ROT_W-1:0]  x_in,
	input  logic signed [awc_pkg::ROT_W-1:0]  y_in,
	input  logic signed [awc_pkg::Z_W-1:0]    z_in,
	output logic signed [awc_pkg::ROT_W-1:0]  x_s1,
	output logic signed [awc_pkg::ROT_W-1:0]  y_s1,
	output logic signed [awc_pkg::Z_W-1:0]    z_s1
);
	import awc_pkg::*;

	logic signed [ROT_W-1:0] xs, ys;
	logic signed [Z_W-1:0]   at;

	assign xs = x_in >>> STEP;
	assign ys = y_in >>> STEP;
	assign at = atan_entry(STEP);

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[Z_W-1]) begin
				x_s1 <= x_in - ys;
				y_s1 <= y_in + xs;
				z_s1 <= z_in - at;
			end else begin
				x_s1 <= x_in + ys;
				y_s1 <= y_in - xs;
				z_s1 <= z_in + at;
			end
		end
	end

endmodule

>>> rtl/awc_vec_cell.sv
// One vectoring CORDIC step of an arctangent chain.
module awc_vec_cell #(
	parameter int STEP = 0
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [awc_pkg::PROD_W-1:0]  x_in,
	input  logic signed [awc_pkg::PROD_W-1:0]  y_in,
	input  logic signed [awc_pkg::Z_W-1:0]     z_in,
	input  awc_pkg::vec_flags_t                fl_in,
	output logic signed [awc_pkg::PROD_W-1:0]  x_s1,
	output logic signed [awc_pkg::PROD_W-1:0]  y_s1,
	output logic signed [awc_pkg::Z_W-1:0]     z_s1,
	output awc_pkg::vec_flags_t                fl_s1
);
	import awc_pkg::*;

	logic signed [PROD_W-1:0] xs, ys;
	logic signed [Z_W-1:0]    at;
	logic                     ypos;

	assign xs   = x_in >>> STEP;
	assign ys   = y_in >>> STEP;
	assign at   = atan_entry(STEP);
	assign ypos = !y_in[PROD_W-1] && (y_in != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			if (ypos) begin
				x_s1 <= x_in + ys;
				y_s1 <= y_in - xs;
				z_s1 <= z_in + at;
			end else begin
				x_s1 <= x_in - ys;
				y_s1 <= y_in + xs;
				z_s1 <= z_in - at;
			end
			fl_s1 <= fl_in;
		end
	end

endmodule

>>> rtl/ackermann_wheel_command_unit.sv
// Top level: wheel rate divider chain and Ackermann steering CORDIC chains.
//
// Takes one drive command per clock unless a result waits at the output, and returns one
// result per command, in order. The wheel rate comes from a chain of 17 + ANGLE_FRAC_BITS
// restoring divider cells, one quotient bit per cell; the wheel angles come from
// CORDIC_STEPS sin/cos rotation cells, a multiply stage, a setup stage and CORDIC_STEPS
// arctangent cells run twice side by side for the inner and outer wheel. The shorter chain
// is padded so both meet at the output register. The whole pipeline stalls as one while a
// result waits at the output; s_tready follows m_tready then.
// Registers are written through cfg_we/cfg_addr/cfg_wdata and must only change while idle.
module ackermann_wheel_command_unit #(
	parameter int ANGLE_FRAC_BITS = awc_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = awc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [awc_pkg::IN_TDATA_W-1:0]      s_tdata,   // speed[15:0], steer_request[29:16]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [awc_pkg::OUT_TDATA_W-1:0]     m_tdata,   // wheel_rate[23:0], left_steer[37:24],
	                                                       // right_steer[51:38]
	input  logic                                cfg_we,
	input  logic [awc_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [awc_pkg::CFG_W-1:0]           cfg_wdata
);
	import awc_pkg::*;

	localparam int SH      = 30 - ANGLE_FRAC_BITS;
	localparam int DW      = 17 + ANGLE_FRAC_BITS;
	localparam int DIV_LAT = DW + 1;
	localparam int ANG_LAT = 2 * CORDIC_STEPS + 3;
	localparam int LAT     = (DIV_LAT > ANG_LAT) ? DIV_LAT : ANG_LAT;
	localparam int DPAD    = LAT - DIV_LAT;
	localparam int APAD    = LAT - ANG_LAT;

	// configuration
	logic [CFG_W-1:0] wheel_radius_q, wheelbase_q, track_width_q;
	logic [LIM_W-1:0] deadband_q, limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_radius_q <= 16'd1000;
			wheelbase_q    <= 16'd1000;
			track_width_q  <= 16'd1000;
			deadband_q     <= 13'd12;
			limit_q        <= 13'd4096;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_WHEEL_RADIUS: wheel_radius_q <= cfg_wdata;
				REG_WHEELBASE:    wheelbase_q    <= cfg_wdata;
				REG_TRACK_WIDTH:  track_width_q  <= cfg_wdata;
				REG_DEADBAND:     deadband_q     <= cfg_wdata[LIM_W-1:0];
				REG_LIMIT:        limit_q        <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control: all stages move together
	logic         adv, acc;
	logic [LAT:0] vld_q;

	assign adv      = !vld_q[LAT] || m_tready;
	assign acc      = s_tvalid && adv;
	assign s_tready = adv;
	assign m_tvalid = vld_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-1:0], acc};
		end
	end

	// input beat decode
	logic signed [SPEED_W-1:0] speed;
	logic signed [STEER_W-1:0] steer;
	logic [SPEED_W-1:0]        spd_mag;
	logic [STEER_W-1:0]        st_mag, st_clip;
	logic                      st_zero;
	logic [39:0]               th_wide;
	logic signed [Z_W-1:0]     th_c;
	logic [DW-1:0]             dvd_c;

	assign speed   = s_tdata[SPEED_W-1:0];
	assign steer   = s_tdata[SPEED_W +: STEER_W];
	assign spd_mag = speed[SPEED_W-1] ? $unsigned(~speed) + 16'd1 : $unsigned(speed);
	assign st_mag  = steer[STEER_W-1] ? $unsigned(~steer) + 14'd1 : $unsigned(steer);
	assign st_zero = st_mag < {1'b0, deadband_q};
	assign st_clip = (st_mag > {1'b0, limit_q}) ? {1'b0, limit_q} : st_mag;
	assign th_wide = 40'(st_clip) << SH;
	assign th_c    = (th_wide > 40'(Q30_HALF_PI)) ? Q30_HALF_PI : Z_W'(th_wide);
	// 2*speed*2^F + r, so the quotient by 2r is rounded half away from zero
	assign dvd_c   = (DW'(spd_mag) << (ANGLE_FRAC_BITS + 1)) + DW'(wheel_radius_q);

	logic [DW-1:0]         dvd_s1;
	logic [REM_W-1:0]      dvs_s1;
	div_flags_t            dfl_s1;
	logic signed [Z_W-1:0] th_s1;
	ang_side_t             side_q [ANG_LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_s1    <= dvd_c;
			dvs_s1    <= {wheel_radius_q, 1'b0};
			dfl_s1    <= '{neg: speed[SPEED_W-1], rz: wheel_radius_q == '0, sz: speed == '0};
			th_s1     <= th_c;
			side_q[0] <= '{sneg: steer[STEER_W-1], nz: !st_zero && (st_clip != '0)};
			for (int k = 1; k < ANG_LAT; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// divider chain
	logic [REM_W-1:0] rem_w [DW+1];
	logic [DW-1:0]    dd_w  [DW+1];
	logic [DW-1:0]    qq_w  [DW+1];
	logic [REM_W-1:0] dv_w  [DW+1];
	div_flags_t       df_w  [DW+1];

	assign rem_w[0] = '0;
	assign dd_w[0]  = dvd_s1;
	assign qq_w[0]  = '0;
	assign dv_w[0]  = dvs_s1;
	assign df_w[0]  = dfl_s1;

	for (genvar i = 0; i < DW; i++) begin : g_div
		awc_div_cell #(.DW(DW)) u_cell (
			.clk    (clk),
			.en     (adv),
			.rem_in (rem_w[i]),
			.dvd_in (dd_w[i]),
			.quo_in (qq_w[i]),
			.dvs_in (dv_w[i]),
			.fl_in  (df_w[i]),
			.rem_s1 (rem_w[i+1]),
			.dvd_s1 (dd_w[i+1]),
			.quo_s1 (qq_w[i+1]),
			.dvs_s1 (dv_w[i+1]),
			.fl_s1  (df_w[i+1])
		);
	end

	div_res_t div_res, div_fin;

	assign div_res.q  = (qq_w[DW] > DW'(RATE_Q_MAX)) ? RATE_Q_MAX : qq_w[DW][RATE_W:0];
	assign div_res.fl = df_w[DW];

	if (DPAD > 0) begin : g_dpad
		div_res_t dpad_q [DPAD];
		always_ff @(posedge clk) begin
			if (adv) begin
				dpad_q[0] <= div_res;
				for (int k = 1; k < DPAD; k++) begin
					dpad_q[k] <= dpad_q[k-1];
				end
			end
		end
		assign div_fin = dpad_q[DPAD-1];
	end else begin : g_dnopad
		assign div_fin = div_res;
	end

	// sin/cos chain
	logic signed [ROT_W-1:0] rx_w [CORDIC_STEPS+1];
	logic signed [ROT_W-1:0] ry_w [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]   rz_w [CORDIC_STEPS+1];

	assign rx_w[0] = GAIN_INV;
	assign ry_w[0] = '0;
	assign rz_w[0] = th_s1;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		awc_rot_cell #(.STEP(i)) u_cell (
			.clk  (clk),
			.en   (adv),
			.x_in (rx_w[i]),
			.y_in (ry_w[i]),
			.z_in (rz_w[i]),
			.x_s1 (rx_w[i+1]),
			.y_s1 (ry_w[i+1]),
			.z_s1 (rz_w[i+1])
		);
	end

	// products: N = 2*L*sin, 2*L*cos, W*sin
	logic signed [PROD_W-1:0] lb_w, tw_w, sn_w, cs_w;
	logic signed [PROD_W-1:0] n_s2, lc_s2, ws_s2;

	assign lb_w = PROD_W'($signed({1'b0, wheelbase_q}));
	assign tw_w = PROD_W'($signed({1'b0, track_width_q}));
	assign sn_w = PROD_W'(ry_w[CORDIC_STEPS]);
	assign cs_w = PROD_W'(rx_w[CORDIC_STEPS]);

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s2  <= (lb_w * sn_w) <<< 1;
			lc_s2 <= (lb_w * cs_w) <<< 1;
			ws_s2 <= tw_w * sn_w;
		end
	end

	// inner and outer divisors, magnitudes and quotient signs
	logic signed [PROD_W-1:0] di_c, do_c, n_abs, di_abs, do_abs;
	logic signed [PROD_W-1:0] vix_s3, viy_s3, vox_s3, voy_s3;
	vec_flags_t               vif_s3, vof_s3;

	assign di_c   = lc_s2 - ws_s2;
	assign do_c   = lc_s2 + ws_s2;
	assign n_abs  = n_s2[PROD_W-1] ? -n_s2 : n_s2;
	assign di_abs = di_c[PROD_W-1] ? -di_c : di_c;
	assign do_abs = do_c[PROD_W-1] ? -do_c : do_c;

	always_ff @(posedge clk) begin
		if (adv) begin
			vix_s3 <= di_abs;
			viy_s3 <= n_abs;
			vox_s3 <= do_abs;
			voy_s3 <= n_abs;
			vif_s3 <= '{neg: n_s2[PROD_W-1] != di_c[PROD_W-1], dz: di_c == '0};
			vof_s3 <= '{neg: n_s2[PROD_W-1] != do_c[PROD_W-1], dz: do_c == '0};
		end
	end

	// arctangent chains
	logic signed [PROD_W-1:0] ix_w [CORDIC_STEPS+1];
	logic signed [PROD_W-1:0] iy_w [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]    iz_w [CORDIC_STEPS+1];
	vec_flags_t               if_w [CORDIC_STEPS+1];
	logic signed [PROD_W-1:0] ox_w [CORDIC_STEPS+1];
	logic signed [PROD_W-1:0] oy_w [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]    oz_w [CORDIC_STEPS+1];
	vec_flags_t               of_w [CORDIC_STEPS+1];

	assign ix_w[0] = vix_s3;
	assign iy_w[0] = viy_s3;
	assign iz_w[0] = '0;
	assign if_w[0] = vif_s3;
	assign ox_w[0] = vox_s3;
	assign oy_w[0] = voy_s3;
	assign oz_w[0] = '0;
	assign of_w[0] = vof_s3;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
		awc_vec_cell #(.STEP(i)) u_inner (
			.clk   (clk),
			.en    (adv),
			.x_in  (ix_w[i]),
			.y_in  (iy_w[i]),
			.z_in  (iz_w[i]),
			.fl_in (if_w[i]),
			.x_s1  (ix_w[i+1]),
			.y_s1  (iy_w[i+1]),
			.z_s1  (iz_w[i+1]),
			.fl_s1 (if_w[i+1])
		);
		awc_vec_cell #(.STEP(i)) u_outer (
			.clk   (clk),
			.en    (adv),
			.x_in  (ox_w[i]),
			.y_in  (oy_w[i]),
			.z_in  (oz_w[i]),
			.fl_in (of_w[i]),
			.x_s1  (ox_w[i+1]),
			.y_s1  (oy_w[i+1]),
			.z_s1  (oz_w[i+1]),
			.fl_s1 (of_w[i+1])
		);
	end

	ang_res_t ang_res, ang_fin;

	assign ang_res.zi   = iz_w[CORDIC_STEPS];
	assign ang_res.zo   = oz_w[CORDIC_STEPS];
	assign ang_res.ifl  = if_w[CORDIC_STEPS];
	assign ang_res.ofl  = of_w[CORDIC_STEPS];
	assign ang_res.side = side_q[ANG_LAT-1];

	if (APAD > 0) begin : g_apad
		ang_res_t apad_q [APAD];
		always_ff @(posedge clk) begin
			if (adv) begin
				apad_q[0] <= ang_res;
				for (int k = 1; k < APAD; k++) begin
					apad_q[k] <= apad_q[k-1];
				end
			end
		end
		assign ang_fin = apad_q[APAD-1];
	end else begin : g_anopad
		assign ang_fin = ang_res;
	end

	// clamp to 0..pi/2, round to output steps, apply quotient sign
	function automatic logic signed [ANG_W-1:0] wheel_angle(
		input logic signed [Z_W-1:0] z,
		input vec_flags_t            fl
	);
		logic [31:0]      zc;
		logic [31:0]      zr;
		logic [ANG_W-1:0] m;
		if (fl.dz) begin
			zc = 32'(Q30_HALF_PI);
		end else if (z[Z_W-1]) begin
			zc = '0;
		end else if (z > Q30_HALF_PI) begin
			zc = 32'(Q30_HALF_PI);
		end else begin
			zc = 32'(z);
		end
		zr = (zc + (32'd1 << (SH - 1))) >> SH;
		m  = ANG_W'(zr);
		return fl.neg ? -m : m;
	endfunction

	logic signed [ANG_W-1:0]  ang_i, ang_o, left_c, right_c;
	logic signed [RATE_W-1:0] rate_c;

	assign ang_i = wheel_angle(ang_fin.zi, ang_fin.ifl);
	assign ang_o = wheel_angle(ang_fin.zo, ang_fin.ofl);

	always_comb begin
		if (!ang_fin.side.nz) begin
			left_c  = '0;
			right_c = '0;
		end else if (ang_fin.side.sneg) begin
			left_c  = -ang_o;
			right_c = -ang_i;
		end else begin
			left_c  = ang_i;
			right_c = ang_o;
		end

		if (div_fin.fl.rz) begin
			if (div_fin.fl.sz) begin
				rate_c = '0;
			end else begin
				rate_c = div_fin.fl.neg ? RATE_NEG_MIN : RATE_POS_MAX;
			end
		end else if (div_fin.fl.neg) begin
			rate_c = RATE_W'(25'd0 - div_fin.q);
		end else begin
			rate_c = (div_fin.q > RATE_Q_MAX - 25'd1) ? RATE_POS_MAX : RATE_W'(div_fin.q);
		end
	end

	// output register
	logic signed [RATE_W-1:0] rate_s4;
	logic signed [ANG_W-1:0]  left_s4, right_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			rate_s4  <= rate_c;
			left_s4  <= left_c;
			right_s4 <= right_c;
		end
	end

	assign m_tdata = OUT_TDATA_W'({right_s4, left_s4, rate_s4});

endmodule
